// ===== rtl/three_axis_scalar_kalman_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the three-axis scalar Kalman unit
// Clocked assertion shorthands used by the checker.
// ---------------------------------------------------------------------------
`ifndef THREE_AXIS_SCALAR_KALMAN_UNIT_MACROS_SVH
`define THREE_AXIS_SCALAR_KALMAN_UNIT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define TSKAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kalman unit check failed");

// Antecedent at one edge requires the consequent at the next edge.
`define TSKAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kalman unit sequence check failed");

`endif

// ===== rtl/tskal_pkg.sv =====
// ---------------------------------------------------------------------------
// Kalman unit package
// Widths, register codes, sequencer states and shared structs.
// ---------------------------------------------------------------------------
package tskal_pkg;

    localparam int CHANNELS_DEF = 3;

    localparam int SAMPLE_W = 16;               // sample and estimate
    localparam int AXIS_W   = 2;
    localparam int CFG_W    = 15;               // Q and R registers
    localparam int VAR_W    = 15;               // stored variance, 0..32767
    localparam int P_W      = 17;               // variance plus Q, and p plus R
    localparam int DIFF_W   = 17;               // sample minus estimate
    localparam int GAIN_W   = 16;               // Q15 gain, 0..32768
    localparam int MUL_W    = 18;               // signed multiplier operands
    localparam int PROD_W   = 2 * MUL_W;
    localparam int Q15_SHIFT = 15;
    localparam int DIV_CNT_W = 4;               // 15 remaining divider steps

    localparam logic [P_W-1:0]   ONE_Q15 = P_W'(32768);
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    typedef enum logic [0:0] {
        CFG_PROCESS_NOISE_Q,
        CFG_MEASURE_NOISE_R
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_GAIN,
        ST_MUL_VAR,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/tskal_if.sv =====
// ---------------------------------------------------------------------------
// Kalman unit channels
// Valid/ready interfaces for measurement samples and filtered results.
// ---------------------------------------------------------------------------
interface tskal_meas_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tskal_pkg::SAMPLE_W-1:0] sample;
    logic [tskal_pkg::AXIS_W-1:0]          axis;

    modport source (output valid, output sample, output axis, input ready);
    modport sink   (input valid, input sample, input axis, output ready);
endinterface

interface tskal_res_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tskal_pkg::SAMPLE_W-1:0] filtered;
    logic                                  axis_error;

    modport source (output valid, output filtered, output axis_error, input ready);
    modport sink   (input valid, input filtered, input axis_error, output ready);
endinterface

// ===== rtl/three_axis_scalar_kalman_unit.sv =====
// ---------------------------------------------------------------------------
// Three-axis scalar Kalman unit
// Q15 scalar Kalman update of a per-axis estimate and variance.
// ---------------------------------------------------------------------------
//  channel   direction   payload                        handshake
//  meas      in          sample[15:0] s, axis[1:0]      valid / ready
//  result    out         filtered[15:0] s, axis_error   valid / ready
//  cfg       in          cfg_addr[0], cfg_wdata[14:0]   cfg_we, no wait
//
// A valid-axis result is registered after acceptance through setup, divider
// load, 15 quotient steps, gain capture, two multiplier passes, write-back and
// output. An invalid-axis result goes from acceptance straight to output.
// meas.ready is high only when idle, so one measurement is in flight at a time.
// A waiting result holds the sequencer in its output state until it is taken.
// Reset clears estimates and variances to zero and Q and R to one.
// ---------------------------------------------------------------------------
module three_axis_scalar_kalman_unit #(
    parameter int CHANNELS = tskal_pkg::CHANNELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_addr,
    input  logic [tskal_pkg::CFG_W-1:0]  cfg_wdata,
    tskal_meas_if.sink                   meas,
    tskal_res_if.source                  result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = tskal_pkg::SAMPLE_W;

    tskal_pkg::state_t                 state_reg, state_next;
    logic [tskal_pkg::CFG_W-1:0]       q_reg, r_reg;

    logic signed [SW-1:0]              est_arr_reg [CHANNELS];
    logic [tskal_pkg::VAR_W-1:0]       var_arr_reg [CHANNELS];

    logic [IDX_W-1:0]                  ax_reg, ax_next;
    logic signed [SW-1:0]              sample_reg, sample_next;
    logic signed [SW-1:0]              est_old_reg, est_old_next;
    logic signed [SW-1:0]              est_new_reg, est_new_next;
    logic [tskal_pkg::P_W-1:0]         p_reg, p_next;
    logic [tskal_pkg::P_W-1:0]         d_reg, d_next;
    logic signed [tskal_pkg::DIFF_W-1:0] diff_reg, diff_next;
    logic [tskal_pkg::GAIN_W-1:0]      gain_reg, gain_next;
    logic                              err_reg, err_next;

    logic                              res_valid_reg, res_valid_next;
    logic signed [SW-1:0]              res_filt_reg, res_filt_next;
    logic                              res_err_reg, res_err_next;

    logic [IDX_W-1:0]                  in_idx;
    logic                              axis_ok;
    logic                              accept;
    logic                              arr_we;
    logic [tskal_pkg::VAR_W-1:0]       var_new;
    logic [tskal_pkg::MUL_W-1:0]       prod_hi;
    logic [tskal_pkg::MUL_W-1:0]       est_sum;

    logic                              div_start;
    tskal_pkg::div_stat_t              div_stat;
    logic [tskal_pkg::GAIN_W-1:0]      div_quot;

    logic signed [tskal_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [tskal_pkg::PROD_W-1:0] mul_prod;

    tskal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (p_reg),
        .den   (d_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    tskal_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    assign in_idx  = IDX_W'(meas.axis);
    assign axis_ok = (4'(meas.axis) < 4'(CHANNELS));
    assign accept  = meas.valid && meas.ready;

    // Product bits 32..15 hold floor(product / 2^15) for both multiplies.
    assign prod_hi = mul_prod[tskal_pkg::Q15_SHIFT + tskal_pkg::MUL_W - 1:tskal_pkg::Q15_SHIFT];
    assign est_sum = {{2{est_old_reg[SW-1]}}, est_old_reg} + prod_hi;
    assign var_new = (|prod_hi[tskal_pkg::MUL_W-1:tskal_pkg::VAR_W]) ? tskal_pkg::VAR_MAX
                                                                      : prod_hi[tskal_pkg::VAR_W-1:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= tskal_pkg::CFG_W'(1);
            r_reg <= tskal_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (tskal_pkg::cfg_reg_t'(cfg_addr))
                tskal_pkg::CFG_PROCESS_NOISE_Q: q_reg <= cfg_wdata;
                tskal_pkg::CFG_MEASURE_NOISE_R: r_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-axis state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                est_arr_reg[i] <= '0;
                var_arr_reg[i] <= '0;
            end
        end
        else if (arr_we)
        begin
            est_arr_reg[ax_reg] <= est_new_reg;
            var_arr_reg[ax_reg] <= var_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tskal_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        sample_reg   <= sample_next;
        est_old_reg  <= est_old_next;
        est_new_reg  <= est_new_next;
        p_reg        <= p_next;
        d_reg        <= d_next;
        diff_reg     <= diff_next;
        gain_reg     <= gain_next;
        err_reg      <= err_next;
        res_filt_reg <= res_filt_next;
        res_err_reg  <= res_err_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        sample_next    = sample_reg;
        est_old_next   = est_old_reg;
        est_new_next   = est_new_reg;
        p_next         = p_reg;
        d_next         = d_reg;
        diff_next      = diff_reg;
        gain_next      = gain_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_filt_next  = res_filt_reg;
        res_err_next   = res_err_reg;
        div_start      = 1'b0;
        arr_we         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        meas.ready     = (state_reg == tskal_pkg::ST_IDLE);

        case (state_reg)
            tskal_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ax_next     = in_idx;
                    sample_next = meas.sample;
                    err_next    = !axis_ok;
                    if (axis_ok)
                    begin
                        p_next     = {2'b00, var_arr_reg[in_idx]} + {2'b00, q_reg};
                        state_next = tskal_pkg::ST_PREP;
                    end
                    else
                    begin
                        state_next = tskal_pkg::ST_OUT;
                    end
                end
            end
            tskal_pkg::ST_PREP:
            begin
                d_next       = p_reg + {2'b00, r_reg};
                est_old_next = est_arr_reg[ax_reg];
                diff_next    = {sample_reg[SW-1], sample_reg}
                             - {est_arr_reg[ax_reg][SW-1], est_arr_reg[ax_reg]};
                state_next   = tskal_pkg::ST_DIV_START;
            end
            tskal_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = tskal_pkg::ST_DIV_WAIT;
            end
            tskal_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    gain_next  = div_quot;
                    state_next = tskal_pkg::ST_MUL_GAIN;
                end
            end
            tskal_pkg::ST_MUL_GAIN:
            begin
                mul_a      = {2'b00, gain_reg};
                mul_b      = {diff_reg[tskal_pkg::DIFF_W-1], diff_reg};
                state_next = tskal_pkg::ST_MUL_VAR;
            end
            tskal_pkg::ST_MUL_VAR:
            begin
                // The correction lies between zero and the difference, so the
                // new estimate always fits the sample width.
                est_new_next = est_sum[SW-1:0];
                mul_a        = {1'b0, p_reg};
                mul_b        = {1'b0, tskal_pkg::ONE_Q15 - {1'b0, gain_reg}};
                state_next   = tskal_pkg::ST_UPDATE;
            end
            tskal_pkg::ST_UPDATE:
            begin
                arr_we     = 1'b1;
                state_next = tskal_pkg::ST_OUT;
            end
            tskal_pkg::ST_OUT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_filt_next  = err_reg ? '0 : est_new_reg;
                    res_err_next   = err_reg;
                    state_next     = tskal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tskal_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid      = res_valid_reg;
    assign result.filtered   = res_filt_reg;
    assign result.axis_error = res_err_reg;

endmodule

// ===== rtl/tskal_div.sv =====
// ---------------------------------------------------------------------------
// Kalman gain divider
// Restoring divider, one quotient bit per cycle: floor(num * 2^15 / den).
// ---------------------------------------------------------------------------
module tskal_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tskal_pkg::P_W-1:0]         num,
    input  logic [tskal_pkg::P_W-1:0]         den,
    output tskal_pkg::div_stat_t              stat,
    output logic [tskal_pkg::GAIN_W-1:0]      quot
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [tskal_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tskal_pkg::P_W-1:0]           rem_reg, rem_next;
    logic [tskal_pkg::P_W-1:0]           den_reg, den_next;
    logic [tskal_pkg::GAIN_W-1:0]        quot_reg, quot_next;
    logic [tskal_pkg::P_W:0]             rem_shift;
    logic                                step_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rem_shift = {rem_reg, 1'b0};
    assign step_bit  = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            den_next = den;
            if (den == '0)
            begin
                // A zero denominator gives a zero gain.
                quot_next = '0;
                done_next = 1'b1;
            end
            else
            begin
                // The integer part of num/den is 0 or 1 since num never exceeds den.
                quot_next = {{(tskal_pkg::GAIN_W-1){1'b0}}, (num >= den)};
                rem_next  = (num >= den) ? (num - den) : num;
                cnt_next  = tskal_pkg::DIV_CNT_W'(tskal_pkg::Q15_SHIFT);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = step_bit ? tskal_pkg::P_W'(rem_shift - {1'b0, den_reg})
                                 : rem_shift[tskal_pkg::P_W-1:0];
            quot_next = {quot_reg[tskal_pkg::GAIN_W-2:0], step_bit};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == tskal_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ===== rtl/tskal_mul.sv =====
// ---------------------------------------------------------------------------
// Kalman shared multiplier
// Signed 18 by 18 multiplier with a registered product.
// ---------------------------------------------------------------------------
module tskal_mul (
    input  logic                                 clk,
    input  logic signed [tskal_pkg::MUL_W-1:0]   a,
    input  logic signed [tskal_pkg::MUL_W-1:0]   b,
    output logic signed [tskal_pkg::PROD_W-1:0]  prod
);

    logic signed [tskal_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/tskal_chk.sv =====
// ---------------------------------------------------------------------------
// Kalman unit port checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "three_axis_scalar_kalman_unit_macros.svh"

module tskal_chk (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  meas_valid,
    input logic                                  meas_ready,
    input logic                                  res_valid,
    input logic                                  res_ready,
    input logic signed [tskal_pkg::SAMPLE_W-1:0] filtered,
    input logic                                  axis_error
);

    // One transaction at a time: ready drops right after an acceptance.
    `TSKAL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, meas_valid && meas_ready, !meas_ready)

    // An error result never carries an estimate.
    `TSKAL_ASSERT(a_error_zero, clk, rst_n, !(res_valid && axis_error) || (filtered == '0))

    // A stalled result stays and keeps its payload.
    `TSKAL_ASSERT_NEXT(a_result_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(filtered) && $stable(axis_error))

endmodule

bind three_axis_scalar_kalman_unit tskal_chk u_tskal_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas_valid (meas.valid),
    .meas_ready (meas.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .filtered   (result.filtered),
    .axis_error (result.axis_error)
);

// ===== verif/three_axis_scalar_kalman_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Three-axis scalar Kalman unit testbench
// Drives measurement transactions through a valid/ready channel and checks
// every filtered result against a built-in Q15 Kalman predictor that keeps
// its own per-axis estimate, variance and noise settings. Noise registers
// are changed between phases while the unit is idle.
// ---------------------------------------------------------------------------
module three_axis_scalar_kalman_unit_tb;

    localparam int     NUM_AXES        = tskal_pkg::CHANNELS_DEF;
    localparam int     SMP_W           = tskal_pkg::SAMPLE_W;
    localparam int     AX_W            = tskal_pkg::AXIS_W;
    localparam int     NOISE_W         = tskal_pkg::CFG_W;
    localparam int     VARM_W          = tskal_pkg::VAR_W;
    localparam int     LONG_HOLD       = 400;
    localparam int     WATCHDOG_LIMIT  = 5000;
    localparam int     SETTLE_CYCLES   = 30;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     RANDOM_PHASES   = 10;
    localparam int     ITEMS_PER_PHASE = 123;
    localparam longint Q15_UNITY       = 32768;
    localparam longint EST_MAX         = 32767;
    localparam longint EST_MIN         = -32768;
    localparam longint VAR_LIMIT       = 32767;

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic [AX_W-1:0]         axis;
        bit                      drain_first;
    } meas_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered;
        logic                    axis_error;
    } kal_out_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_addr;
    logic [NOISE_W-1:0] cfg_wdata;

    tskal_meas_if meas_ch ();
    tskal_res_if  res_ch ();

    three_axis_scalar_kalman_unit #(
        .CHANNELS (NUM_AXES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .meas      (meas_ch),
        .result    (res_ch)
    );

    // Predictor state.
    logic signed [SMP_W-1:0] est_model [NUM_AXES];
    logic [VARM_W-1:0]       var_model [NUM_AXES];
    logic [NOISE_W-1:0]      q_model;
    logic [NOISE_W-1:0]      r_model;

    logic signed [SMP_W-1:0] trend [NUM_AXES];
    meas_item_t              sample_queue [$];
    kal_out_t                pending_estimates [$];

    int issued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int idle_cycles    = 0;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_left      = 0;
    bit meas_taken     = 1'b0;
    bit steady_flow    = 1'b0;
    bit hold_req       = 1'b0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic kal_out_t apply_measurement(logic signed [SMP_W-1:0] smp,
                                                   logic [AX_W-1:0] ax);
        longint   p;
        longint   denom;
        longint   gain;
        longint   step;
        longint   upd;
        longint   nv;
        kal_out_t o;
        if (ax >= NUM_AXES)
        begin
            o.filtered   = '0;
            o.axis_error = 1'b1;
            return o;
        end
        p     = longint'(var_model[ax]) + longint'(q_model);
        denom = p + longint'(r_model);
        gain  = (denom == 0) ? 0 : (p <<< tskal_pkg::Q15_SHIFT) / denom;
        // Arithmetic shift of the signed product floors toward minus infinity.
        step  = gain * (longint'(smp) - longint'(est_model[ax]));
        upd   = longint'(est_model[ax]) + (step >>> tskal_pkg::Q15_SHIFT);
        if (upd > EST_MAX)
            upd = EST_MAX;
        if (upd < EST_MIN)
            upd = EST_MIN;
        nv = (p * (Q15_UNITY - gain)) >>> tskal_pkg::Q15_SHIFT;
        if (nv > VAR_LIMIT)
            nv = VAR_LIMIT;
        est_model[ax] = SMP_W'(upd);
        var_model[ax] = VARM_W'(nv);
        o.filtered    = SMP_W'(upd);
        o.axis_error  = 1'b0;
        return o;
    endfunction

    // Mostly back-to-back, sometimes short pauses, rarely long ones.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (steady_flow || k < 50)
            return 0;
        if (k < 85)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [NOISE_W-1:0] pick_noise();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0:       return '0;
            1:       return NOISE_W'(1);
            2:       return {NOISE_W{1'b1}};
            3, 4:    return NOISE_W'($urandom_range(0, 64));
            default: return NOISE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic push_item(logic signed [SMP_W-1:0] smp, logic [AX_W-1:0] ax,
                             bit drain_first);
        meas_item_t it;
        it.sample      = smp;
        it.axis        = ax;
        it.drain_first = drain_first;
        sample_queue.push_back(it);
        issued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != issued_count || pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_noise_reg(tskal_pkg::cfg_reg_t idx, logic [NOISE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == tskal_pkg::CFG_PROCESS_NOISE_Q)
            q_model = value;
        else
            r_model = value;
    endtask

    task automatic start_phase(logic [NOISE_W-1:0] q, logic [NOISE_W-1:0] r);
        wait_idle();
        write_noise_reg(tskal_pkg::CFG_PROCESS_NOISE_Q, q);
        write_noise_reg(tskal_pkg::CFG_MEASURE_NOISE_R, r);
        @(posedge clk);
    endtask

    // A mix of slowly drifting signals with noise, raw random words and
    // full-scale values, with an invalid axis now and then.
    task automatic push_random_items(int count);
        logic signed [SMP_W-1:0] smp;
        logic [AX_W-1:0]         ax;
        int                      k;
        for (int i = 0; i < count; i++)
        begin
            ax = ($urandom_range(0, 9) == 0) ? AX_W'(NUM_AXES) : AX_W'($urandom_range(0, 2));
            k  = $urandom_range(0, 9);
            if (k < 4)
                smp = SMP_W'($urandom);
            else if (k < 8)
            begin
                if (ax < NUM_AXES)
                begin
                    if ($urandom_range(0, 19) == 0)
                        trend[ax] = SMP_W'($urandom);
                    smp = trend[ax] + SMP_W'($urandom_range(0, 255)) - SMP_W'(128);
                end
                else
                    smp = SMP_W'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       smp = SMP_W'(EST_MAX);
                    1:       smp = SMP_W'(EST_MIN);
                    2:       smp = '0;
                    default: smp = '1;
                endcase
            end
            push_item(smp, ax, $urandom_range(0, 49) == 0);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        meas_ch.valid  = 1'b0;
        meas_ch.sample = '0;
        meas_ch.axis   = '0;
        res_ch.ready   = 1'b0;
        q_model        = NOISE_W'(1);
        r_model        = NOISE_W'(1);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            est_model[a] = '0;
            var_model[a] = '0;
            trend[a]     = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero denominator: variance, Q and R all zero leave the state alone.
        start_phase('0, '0);
        push_item(SMP_W'(EST_MAX), 2'd0, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd1, 1'b0);
        push_item('0, 2'd2, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd3, 1'b0);
        push_item(SMP_W'(EST_MAX), 2'd3, 1'b0);

        // Zero measurement noise: the estimate snaps to the sample, including
        // the widest possible difference between the two.
        start_phase(NOISE_W'(1), '0);
        push_item(SMP_W'(EST_MAX), 2'd0, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd0, 1'b0);
        push_item('1, 2'd1, 1'b0);
        push_item(SMP_W'(12345), 2'd2, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd2, 1'b0);

        // Largest noise settings push the variance toward saturation.
        start_phase({NOISE_W{1'b1}}, {NOISE_W{1'b1}});
        push_item(SMP_W'(EST_MAX), 2'd0, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd0, 1'b0);
        push_item(SMP_W'(EST_MAX), 2'd1, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd2, 1'b1);
        push_item(SMP_W'(EST_MAX), 2'd2, 1'b0);
        push_item(16'sh5555, 2'd3, 1'b0);

        start_phase({NOISE_W{1'b1}}, NOISE_W'(1));
        push_item(16'sh2AAA, 2'd1, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd1, 1'b0);
        push_item(16'sh7F00, 2'd2, 1'b0);

        start_phase('0, {NOISE_W{1'b1}});
        push_item(SMP_W'(EST_MAX), 2'd0, 1'b0);
        push_item(SMP_W'(EST_MIN), 2'd1, 1'b0);
        push_item('1, 2'd2, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            start_phase(pick_noise(), pick_noise());
            steady_flow = (ph == 4);
            push_random_items(ITEMS_PER_PHASE);
            // Hold the result side off while items keep coming, so the unit
            // backs up and stalls its input.
            if (ph == 2)
                hold_req = 1'b1;
        end

        while (accepted_count != issued_count || pending_estimates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_estimates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_estimates.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Measurement driver.
    always @(negedge clk)
    begin
        meas_item_t it;
        if (rst_n !== 1'b1)
            meas_ch.valid <= 1'b0;
        else if (meas_ch.valid && !meas_taken)
        begin
            // Hold the offered transaction until it is taken.
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            meas_ch.valid <= 1'b0;
        end
        else if (sample_queue.size() > 0 &&
                 !(sample_queue[0].drain_first && pending_estimates.size() != 0))
        begin
            it = sample_queue.pop_front();
            meas_ch.valid  <= 1'b1;
            meas_ch.sample <= it.sample;
            meas_ch.axis   <= it.axis;
            send_gap = pick_gap();
        end
        else
            meas_ch.valid <= 1'b0;
    end

    // Result receiver.
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
            res_ch.ready <= 1'b0;
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge clk)
    begin
        kal_out_t want;
        bit       res_taken;
        if (rst_n === 1'b1)
        begin
            meas_taken = meas_ch.valid && meas_ch.ready;
            res_taken  = res_ch.valid && res_ch.ready;
            if (meas_taken)
            begin
                pending_estimates.push_back(apply_measurement(meas_ch.sample, meas_ch.axis));
                accepted_count++;
            end
            if (res_taken)
            begin
                if (pending_estimates.size() == 0)
                    report_mismatch($sformatf("result transaction with none expected: %0d/%b",
                                              res_ch.filtered, res_ch.axis_error));
                else
                begin
                    want = pending_estimates.pop_front();
                    if (res_ch.filtered !== want.filtered)
                        report_mismatch($sformatf("filtered %0d, expected %0d",
                                                  res_ch.filtered, want.filtered));
                    if (res_ch.axis_error !== want.axis_error)
                        report_mismatch($sformatf("axis_error %b, expected %b",
                                                  res_ch.axis_error, want.axis_error));
                end
            end
            if (meas_taken || res_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
        else
            meas_taken = 1'b0;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tskal_pkg.sv
rtl/tskal_if.sv
rtl/tskal_div.sv
rtl/tskal_mul.sv
rtl/three_axis_scalar_kalman_unit.sv
rtl/tskal_chk.sv
verif/three_axis_scalar_kalman_unit_tb.sv
